[rtl/msf_pkg.sv]
// shared constants, types and controller/datapath structs for the message framer
package msf_pkg;

   localparam int FRAME_PAYLOAD_DEF = 30;
   localparam int BYTE_W            = 8;
   localparam int ADDR_W            = 7;
   localparam int PADDR_W           = 3;
   localparam int PDATA_W           = 32;

   localparam logic [ADDR_W-1:0] TARGET_ADDRESS_RESET = 7'd8;

   // header byte codes
   localparam logic [BYTE_W-1:0] HDR_FIRST = 8'd6;
   localparam logic [BYTE_W-1:0] HDR_CONT  = 8'd7;
   localparam logic [BYTE_W-1:0] HDR_LAST  = 8'd8;

   // register index of target_address
   localparam logic REG_TARGET_ADDRESS = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR0,
      ST_HDR1,
      ST_PAY,
      ST_STORE
   } state_type;

   typedef enum logic [1:0] {
      SEL_HDR0,
      SEL_HDR1,
      SEL_PAY
   } outsel_type;

   typedef struct packed {
      logic       latch;
      logic       store;
      logic       load;
      outsel_type sel;
      logic       final_frame;
      logic       rd_first;
      logic       rd_next;
      logic       frame_done;
      logic       msg_done;
      logic       end_mark;
      logic       run_last;
   } cmd_type;

   typedef struct packed {
      logic fill_full;
      logic slot_free;
      logic last_byte;
      logic pay_end;
   } status_type;

endpackage

[rtl/msf_req_if.sv]
// input channel: message byte with last-byte flag
interface msf_req_if;
   import msf_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              last_byte;

   modport source (output valid, text_byte, last_byte, input ready);
   modport sink   (input valid, text_byte, last_byte, output ready);
endinterface

[rtl/msf_rsp_if.sv]
// result channel: one bus byte per word with framing marks
interface msf_rsp_if;
   import msf_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic [ADDR_W-1:0] dest_address;
   logic              frame_start;
   logic              frame_end;
   logic              run_last;

   modport source (output valid, out_byte, dest_address, frame_start, frame_end, run_last,
                   input ready);
   modport sink   (input valid, out_byte, dest_address, frame_start, frame_end, run_last,
                   output ready);
endinterface

[rtl/msf_ram.sv]
// generic single-write, single-read ram with registered read data
module msf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 30
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[rtl/msf_csr.sv]
// apb register block holding the target bus address
module msf_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [msf_pkg::PADDR_W-1:0]     paddr,
   input  logic [msf_pkg::PDATA_W-1:0]     pwdata,
   output logic [msf_pkg::PDATA_W-1:0]     prdata,
   output logic                            pready,
   output logic [msf_pkg::ADDR_W-1:0]      target_address
);
   import msf_pkg::*;

   logic [ADDR_W-1:0] target_ff;
   logic [ADDR_W-1:0] target_in;
   logic              hit;

   // word index is the top address bit
   assign hit = (paddr[PADDR_W-1] == REG_TARGET_ADDRESS);

   always_comb begin
      target_in = target_ff;
      if (psel && penable && pwrite && hit) begin
         target_in = pwdata[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_ADDRESS_RESET;
      end else begin
         target_ff <= target_in;
      end
   end

   assign prdata         = hit ? {{(PDATA_W-ADDR_W){1'b0}}, target_ff} : '0;
   assign pready         = 1'b1;
   assign target_address = target_ff;
endmodule

[rtl/msf_ctrl.sv]
// framer controller: sequences store, headers and payload readout
module msf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  msf_pkg::status_type status,
   output msf_pkg::cmd_type    cmd
);
   import msf_pkg::*;

   state_type state_ff, state_in;
   logic      final_ff, final_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      final_in = final_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.fill_full) begin
                  // full buffer goes out as a non-final frame first
                  final_in = 1'b0;
                  state_in = ST_HDR0;
               end else begin
                  state_in = ST_STORE;
               end
            end
         end
         ST_STORE: begin
            if (status.last_byte) begin
               final_in = 1'b1;
               state_in = ST_HDR0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_HDR0: begin
            if (status.slot_free) begin
               state_in = ST_HDR1;
            end
         end
         ST_HDR1: begin
            if (status.slot_free) begin
               state_in = ST_PAY;
            end
         end
         ST_PAY: begin
            if (status.slot_free && status.pay_end) begin
               state_in = final_ff ? ST_IDLE : ST_STORE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd             = '0;
      cmd.sel         = SEL_HDR0;
      cmd.final_frame = final_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.latch = accept;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
         end
         ST_HDR0: begin
            cmd.load = status.slot_free;
            cmd.sel  = SEL_HDR0;
         end
         ST_HDR1: begin
            cmd.load     = status.slot_free;
            cmd.sel      = SEL_HDR1;
            cmd.rd_first = status.slot_free;
         end
         ST_PAY: begin
            cmd.load = status.slot_free;
            cmd.sel  = SEL_PAY;
            if (status.slot_free) begin
               if (status.pay_end) begin
                  cmd.end_mark   = 1'b1;
                  cmd.run_last   = final_ff || !status.last_byte;
                  cmd.frame_done = 1'b1;
                  cmd.msg_done   = final_ff;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
      end
   end
endmodule

[rtl/msf_dpath.sv]
// framer datapath: payload buffer, fill and read counters, output register
module msf_dpath #(
   parameter int FRAME_PAYLOAD = msf_pkg::FRAME_PAYLOAD_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  msf_pkg::cmd_type              cmd,
   output msf_pkg::status_type           status,
   input  logic [msf_pkg::BYTE_W-1:0]    in_text_byte,
   input  logic                          in_last_byte,
   input  logic [msf_pkg::ADDR_W-1:0]    target_address,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [msf_pkg::BYTE_W-1:0]    out_byte,
   output logic [msf_pkg::ADDR_W-1:0]    out_dest_address,
   output logic                          out_frame_start,
   output logic                          out_frame_end,
   output logic                          out_run_last
);
   import msf_pkg::*;

   localparam int AW = (FRAME_PAYLOAD > 1) ? $clog2(FRAME_PAYLOAD) : 1;
   localparam int FW = $clog2(FRAME_PAYLOAD + 1);

   logic [BYTE_W-1:0] byte_ff;
   logic              last_ff;
   logic [FW-1:0]     fill_ff, fill_in;
   logic              sent_ff, sent_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     idx_next;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] obyte_ff, obyte_in;
   logic [ADDR_W-1:0] oaddr_ff;
   logic              ostart_ff, oend_ff, orun_ff;

   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   assign idx_next = AW'(idx_ff + AW'(1));

   msf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FRAME_PAYLOAD)
   ) u_buf (
      .clock (clock),
      .we    (cmd.store),
      .waddr (fill_ff[AW-1:0]),
      .wdata (byte_ff),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign ram_re    = cmd.rd_first || cmd.rd_next;
   assign ram_raddr = cmd.rd_first ? '0 : idx_next;

   always_comb begin
      fill_in = fill_ff;
      if (cmd.frame_done) begin
         fill_in = '0;
      end else if (cmd.store) begin
         fill_in = FW'(fill_ff + FW'(1));
      end

      sent_in = sent_ff;
      if (cmd.msg_done) begin
         sent_in = 1'b0;
      end else if (cmd.frame_done) begin
         sent_in = 1'b1;
      end

      idx_in = idx_ff;
      if (cmd.rd_first) begin
         idx_in = '0;
      end else if (cmd.rd_next) begin
         idx_in = idx_next;
      end

      case (cmd.sel)
         SEL_HDR0: obyte_in = sent_ff ? HDR_CONT : HDR_FIRST;
         SEL_HDR1: obyte_in = cmd.final_frame ? HDR_LAST : HDR_CONT;
         SEL_PAY:  obyte_in = ram_rdata;
         default:  obyte_in = ram_rdata;
      endcase

      valid_in = valid_ff;
      if (cmd.load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         sent_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         sent_ff  <= sent_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.latch) begin
         byte_ff <= in_text_byte;
         last_ff <= in_last_byte;
      end
      if (cmd.load) begin
         obyte_ff  <= obyte_in;
         oaddr_ff  <= target_address;
         ostart_ff <= (cmd.sel == SEL_HDR0);
         oend_ff   <= cmd.end_mark;
         orun_ff   <= cmd.run_last;
      end
   end

   assign status.fill_full = (fill_ff == FW'(FRAME_PAYLOAD));
   assign status.slot_free = !valid_ff || out_ready;
   assign status.last_byte = last_ff;
   assign status.pay_end   = (FW'(idx_ff) == FW'(fill_ff - FW'(1)));

   assign out_valid        = valid_ff;
   assign out_byte         = obyte_ff;
   assign out_dest_address = oaddr_ff;
   assign out_frame_start  = ostart_ff;
   assign out_frame_end    = oend_ff;
   assign out_run_last     = orun_ff;
endmodule

[rtl/message_segmenting_framer_unit.sv]
// Message segmenting framer, top level.
// req_ch takes one message byte per word with a last-byte flag; rsp_ch gives one
// bus byte per word. Each frame is two header bytes (6,8 single; 6,7 first;
// 7,7 middle; 7,8 last) and then up to FRAME_PAYLOAD payload bytes, with
// frame_start on the first header byte, frame_end on the final payload byte
// and run_last on the last word caused by an input word.
// The target bus address is set through the APB port (register 0, reset 8)
// and is sampled as each byte goes out.
// An input word is accepted and then stored into the payload ram.
// A word that completes or overflows a frame also drives the frame out at one
// word per cycle from the output register unless the receiver stalls: 2 headers
// plus n payload bytes, paced by the single ram read port; input is held off
// until that is done. The output register decouples the sides: a stalled
// receiver only holds the frame readout, and the next input word can be accepted
// while the final word still waits. Reset empties the buffer and the output
// register; the buffer contents need no clearing.
module message_segmenting_framer_unit #(
   parameter int FRAME_PAYLOAD = msf_pkg::FRAME_PAYLOAD_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   msf_req_if.sink                     req_ch,
   msf_rsp_if.source                   rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [msf_pkg::PADDR_W-1:0] paddr,
   input  logic [msf_pkg::PDATA_W-1:0] pwdata,
   output logic [msf_pkg::PDATA_W-1:0] prdata,
   output logic                        pready
);
   import msf_pkg::*;

   cmd_type           cmd;
   status_type        status;
   logic [ADDR_W-1:0] target_address;

   msf_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .target_address (target_address)
   );

   msf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   msf_dpath #(
      .FRAME_PAYLOAD (FRAME_PAYLOAD)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .in_text_byte     (req_ch.text_byte),
      .in_last_byte     (req_ch.last_byte),
      .target_address   (target_address),
      .out_valid        (rsp_ch.valid),
      .out_ready        (rsp_ch.ready),
      .out_byte         (rsp_ch.out_byte),
      .out_dest_address (rsp_ch.dest_address),
      .out_frame_start  (rsp_ch.frame_start),
      .out_frame_end    (rsp_ch.frame_end),
      .out_run_last     (rsp_ch.run_last)
   );
endmodule

[rtl/msf_checker.sv]
// port-level checks on the framer output, bound to the top level
module msf_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [msf_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic                       rsp_frame_start,
   input logic                       rsp_frame_end,
   input logic                       rsp_run_last
);
   import msf_pkg::*;

   // stalled word must stay put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("result word changed while stalled");

   a_start_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_start |-> rsp_out_byte == HDR_FIRST || rsp_out_byte == HDR_CONT)
      else $error("frame start on a non-header byte");

   a_start_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_start |-> !rsp_frame_end)
      else $error("frame start and end on one word");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_last |-> rsp_frame_end)
      else $error("run ended inside a frame");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
endmodule

bind message_segmenting_framer_unit msf_checker u_msf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_out_byte    (rsp_ch.out_byte),
   .rsp_frame_start (rsp_ch.frame_start),
   .rsp_frame_end   (rsp_ch.frame_end),
   .rsp_run_last    (rsp_ch.run_last)
);

[bench/tb_message_segmenting_framer_unit.sv]
// testbench for the message framer: directed and random messages checked word by word
`timescale 1ns / 100ps

module tb_message_segmenting_framer_unit;
   import msf_pkg::*;

   localparam int FRAME_PAYLOAD = FRAME_PAYLOAD_DEF;
   localparam int N_PHASES      = 6;
   localparam int PHASE_BYTES   = 26;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [ADDR_W-1:0] dest_address;
      logic              frame_start;
      logic              frame_end;
      logic              run_last;
   } bus_word_t;

   // literal rows are single-byte messages sent at the reset address
   typedef struct packed {
      logic [BYTE_W-1:0] msg_byte;
      logic              is_last;
      logic              literal;
      logic [BYTE_W-1:0] hdr0;
      logic [BYTE_W-1:0] hdr1;
   } directed_row_t;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic pready;

   msf_req_if req_ch ();
   msf_rsp_if rsp_ch ();

   message_segmenting_framer_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   directed_row_t directed_rows [12] = '{
      '{8'h00, 1'b1, 1'b1, HDR_FIRST, HDR_LAST},
      '{8'hFF, 1'b1, 1'b1, HDR_FIRST, HDR_LAST},
      '{8'h06, 1'b1, 1'b1, HDR_FIRST, HDR_LAST},
      '{8'h08, 1'b1, 1'b1, HDR_FIRST, HDR_LAST},
      '{8'h55, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'hAA, 1'b1, 1'b0, 8'h00, 8'h00},
      '{8'h07, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h80, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h7F, 1'b1, 1'b0, 8'h00, 8'h00},
      '{8'h01, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'hFE, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'hF0, 1'b1, 1'b0, 8'h00, 8'h00}
   };

   // framer state as seen from outside
   logic [BYTE_W-1:0] held_bytes [FRAME_PAYLOAD];
   int                held_count  = 0;
   bit                frame_sent  = 1'b0;
   logic [ADDR_W-1:0] target_addr = TARGET_ADDRESS_RESET;

   bus_word_t pending_bus_words [$];
   int        error_count   = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void queue_frame(input bit final_frame, ref bus_word_t words[$]);
      logic [BYTE_W-1:0] h0;
      logic [BYTE_W-1:0] h1;
      h0 = frame_sent ? HDR_CONT : HDR_FIRST;
      h1 = final_frame ? HDR_LAST : HDR_CONT;
      words.push_back(bus_word_t'({h0, target_addr, 1'b1, 1'b0, 1'b0}));
      words.push_back(bus_word_t'({h1, target_addr, 1'b0, held_count == 0, 1'b0}));
      for (int i = 0; i < held_count; i++)
         words.push_back(bus_word_t'({held_bytes[i], target_addr, 1'b0,
                                      i + 1 == held_count, 1'b0}));
      held_count = 0;
      frame_sent = 1'b1;
   endfunction

   function automatic void frame_message_byte(input logic [BYTE_W-1:0] msg_byte,
                                              input logic is_last,
                                              ref bus_word_t words[$]);
      words.delete();
      // a full buffer goes out as a non-final frame before the byte is kept
      if (held_count >= FRAME_PAYLOAD)
         queue_frame(1'b0, words);
      held_bytes[held_count] = msg_byte;
      held_count++;
      if (is_last) begin
         queue_frame(1'b1, words);
         held_count = 0;
         frame_sent = 1'b0;
      end
      if (words.size() > 0)
         words[words.size() - 1].run_last = 1'b1;
   endfunction

   task automatic push_byte(input logic [BYTE_W-1:0] msg_byte, input logic is_last,
                            input bit drain_first, ref bus_word_t words[$]);
      if (drain_first || $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while (drain_first && pending_bus_words.size() != 0) @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.text_byte <= msg_byte;
      req_ch.last_byte <= is_last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      frame_message_byte(msg_byte, is_last, words);
   endtask

   task automatic write_register(input logic [PADDR_W-1:0] addr,
                                 input logic [PDATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // byte still being stored after the last word came out
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_bus_words.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_words
      bus_word_t got;
      bus_word_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = bus_word_t'({rsp_ch.out_byte, rsp_ch.dest_address, rsp_ch.frame_start,
                            rsp_ch.frame_end, rsp_ch.run_last});
         if (pending_bus_words.size() == 0) begin
            $display("%0t: unexpected word byte %h addr %h start %b end %b last %b",
                     $time, got.out_byte, got.dest_address, got.frame_start,
                     got.frame_end, got.run_last);
            error_count++;
         end else begin
            want = pending_bus_words.pop_front();
            if (got !== want) begin
               $display("%0t: expected byte %h addr %h start %b end %b last %b",
                        $time, want.out_byte, want.dest_address, want.frame_start,
                        want.frame_end, want.run_last);
               $display("%0t:      got byte %h addr %h start %b end %b last %b",
                        $time, got.out_byte, got.dest_address, got.frame_start,
                        got.frame_end, got.run_last);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      bus_word_t         words [$];
      directed_row_t     row;
      logic [ADDR_W-1:0] new_addr;
      int                sent;
      int                total;
      int                msg_left;
      int                forced_len;
      bit                drain;

      total      = 0;
      msg_left   = 0;
      forced_len = 0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.text_byte = '0;
      req_ch.last_byte = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 13;
      recv_idle_pct = 80;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         push_byte(row.msg_byte, row.is_last, 1'b0, words);
         if (row.literal) begin
            words.delete();
            words.push_back(bus_word_t'({row.hdr0, TARGET_ADDRESS_RESET, 3'b100}));
            words.push_back(bus_word_t'({row.hdr1, TARGET_ADDRESS_RESET, 3'b000}));
            words.push_back(bus_word_t'({row.msg_byte, TARGET_ADDRESS_RESET, 3'b011}));
         end
         foreach (words[k]) pending_bus_words.push_back(words[k]);
      end

      for (int phase = 0; phase < N_PHASES; phase++) begin
         settle();
         case (phase)
            0: new_addr = 7'h7F;
            1: new_addr = 7'h00;
            default: new_addr = ADDR_W'($urandom_range(127));
         endcase
         write_register(PADDR_W'(4 * REG_TARGET_ADDRESS), PDATA_W'(new_addr));
         target_addr = new_addr;
         case (phase / 2)
            0: begin
               send_idle_pct = 13;
               recv_idle_pct = 80;
            end
            1: begin
               send_idle_pct = 80;
               recv_idle_pct = 13;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // exact multiple, full buffer plus last byte, and a middle frame
         case (phase)
            0: forced_len = FRAME_PAYLOAD;
            2: forced_len = FRAME_PAYLOAD + 1;
            4: forced_len = 2 * FRAME_PAYLOAD + 1;
            default: ;
         endcase
         sent = 0;
         while (sent < PHASE_BYTES) begin
            if (msg_left == 0) begin
               if (forced_len != 0) begin
                  msg_left   = forced_len;
                  forced_len = 0;
               end else if ($urandom_range(7) == 0) begin
                  msg_left = FRAME_PAYLOAD - 1 + $urandom_range(2)
                             + FRAME_PAYLOAD * $urandom_range(1);
               end else begin
                  msg_left = $urandom_range(6, 1);
               end
            end
            drain = (total == 45) || ($urandom_range(39) == 0);
            push_byte(ADDR_W'(0) | BYTE_W'($urandom_range(255)), msg_left == 1, drain, words);
            foreach (words[k]) pending_bus_words.push_back(words[k]);
            msg_left--;
            sent++;
            total++;
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("tb_message_segmenting_framer_unit passed");
      else
         $display("tb_message_segmenting_framer_unit failed");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("%0t: timeout with %0d words still expected", $time,
               pending_bus_words.size());
      $display("tb_message_segmenting_framer_unit failed");
      $finish;
   end

endmodule
